### sv/rqms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rqms_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORNERS      = 4;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int IDX_W        = $clog2(CORNERS);

  localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;
  localparam logic signed [20:0] PI_Q16      = 21'sd205887;
  localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
  localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;
  localparam logic [16:0] GAIN_ONE = 17'd65536;
  // multiple of 2pi that lifts any 32-bit angle to a non-negative value
  localparam logic [32:0] MOD_BIAS = 33'd2147818400;
  // floor(2^51 / 2pi): quotient estimate is exact or one short
  localparam logic signed [33:0] MOD_RECIP = 34'sd5468519977;
  localparam int RECIP_SHIFT = 51;
  localparam int QUOT_W      = 15;
  // angle reduction phases
  localparam int MOD_STEPS = 4;
  localparam logic [STEP_W-1:0] MOD_QUOT = STEP_W'(0);
  localparam logic [STEP_W-1:0] MOD_TAKE = STEP_W'(1);
  localparam logic [STEP_W-1:0] MOD_BACK = STEP_W'(2);
  localparam logic [STEP_W-1:0] MOD_REM  = STEP_W'(3);
  localparam int CNT_W    = 6;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_CORNER = 2'd1,
    CMD_SPEED  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_LEFT  = 3'd0,
    REG_RIGHT = 3'd1,
    REG_DOWN  = 3'd2,
    REG_UP    = 3'd3,
    REG_GAIN  = 3'd4,
    REG_RATE  = 3'd5
  } reg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_DX, OP_DY, OP_ANG, OP_HIT, OP_BX, OP_BY, OP_RX, OP_RY,
    OP_MODI, OP_MOD, OP_FOLD, OP_CORD, OP_SC, OP_REL, OP_P0, OP_P1, OP_P2,
    OP_P3, OP_P4, OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DX, S_DY, S_ANG, S_HIT, S_BX, S_BY, S_RX, S_RY, S_MODI, S_MOD,
    S_FOLD, S_CORD, S_SC, S_REL, S_P0, S_P1, S_P2, S_P3, S_P4, S_EMIT
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [STEP_W-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  function automatic logic [31:0] sat40(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -40'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] i);
    case (i)
      0: return 32'd843314857;
      1: return 32'd497837829;
      2: return 32'd263043837;
      3: return 32'd133525159;
      4: return 32'd67021687;
      5: return 32'd33543516;
      6: return 32'd16775851;
      7: return 32'd8388437;
      8: return 32'd4194283;
      9: return 32'd2097149;
      10: return 32'd1048576;
      default: return 32'd1 << (6'd30 - 6'(i));
    endcase
  endfunction

endpackage
`default_nettype wire

### sv/rqms_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rqms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  vertex_index;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic [15:0] time_step;
  modport source (output valid, cmd, vertex_index, x_value, y_value, time_step,
                  input ready);
  modport sink (input valid, cmd, vertex_index, x_value, y_value, time_step,
                output ready);
endinterface

interface rqms_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  corner_index;
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic        last;
  modport source (output valid, corner_index, x_pos, y_pos, last, input ready);
  modport sink (input valid, corner_index, x_pos, y_pos, last, output ready);
endinterface
`default_nettype wire

### sv/rigid_quad_motion_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Rigid quad motion step: holds four Q16.16 corners and a velocity. Load
// commands (corner, velocity) are taken while idle and give no result. A tick
// bounces each axis off the walls at most once, moves the corners by
// velocity times the step, spins them about the pre-move center and then
// delivers four corner transfers, last set on corner 3. A tick runs setup,
// bounce and center, the angle reduction (reciprocal multiply, back-multiply
// and one correcting subtract), the shared CORDIC and then each corner on
// the one shared multiplier, and waits on any output stall. The input is
// taken again once the last corner sits in the output register. Write the
// config port only while the block is idle.
module rigid_quad_motion_step_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  rqms_in_if.sink          in_ch,
  rqms_out_if.source       out_ch
);

  rqms_pkg::dp_cmd_t  cmd;
  rqms_pkg::dp_stat_t stat;
  logic in_ready;

  // sequencer: walks bounce, move, reduce, CORDIC and per-corner rotate
  rqms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // state, config registers, shared multiplier and result register
  rqms_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

### sv/rqms_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rqms_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_cmd,
  output logic               in_ready,
  input  rqms_pkg::dp_stat_t stat,
  output rqms_pkg::dp_cmd_t  cmd
);

  rqms_pkg::state_t state_r, state_nxt;
  logic [rqms_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rqms_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd.op    = rqms_pkg::OP_NONE;
    cmd.idx   = cnt_r[rqms_pkg::IDX_W-1:0];
    cmd.step  = cnt_r[rqms_pkg::STEP_W-1:0];
    unique case (state_r)
      rqms_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.op = rqms_pkg::OP_LOAD;
          if (in_cmd == rqms_pkg::CMD_TICK) state_nxt = rqms_pkg::S_DX;
        end
      end
      rqms_pkg::S_DX:  begin cmd.op = rqms_pkg::OP_DX;  state_nxt = rqms_pkg::S_DY;  end
      rqms_pkg::S_DY:  begin cmd.op = rqms_pkg::OP_DY;  state_nxt = rqms_pkg::S_ANG; end
      rqms_pkg::S_ANG: begin cmd.op = rqms_pkg::OP_ANG; state_nxt = rqms_pkg::S_HIT; end
      rqms_pkg::S_HIT: begin
        cmd.op = rqms_pkg::OP_HIT;
        if (cnt_r == rqms_pkg::CNT_W'(rqms_pkg::CORNERS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = rqms_pkg::S_BX;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      rqms_pkg::S_BX:   begin cmd.op = rqms_pkg::OP_BX;   state_nxt = rqms_pkg::S_BY;   end
      rqms_pkg::S_BY:   begin cmd.op = rqms_pkg::OP_BY;   state_nxt = rqms_pkg::S_RX;   end
      rqms_pkg::S_RX:   begin cmd.op = rqms_pkg::OP_RX;   state_nxt = rqms_pkg::S_RY;   end
      rqms_pkg::S_RY:   begin cmd.op = rqms_pkg::OP_RY;   state_nxt = rqms_pkg::S_MODI; end
      rqms_pkg::S_MODI: begin cmd.op = rqms_pkg::OP_MODI; state_nxt = rqms_pkg::S_MOD;  end
      rqms_pkg::S_MOD: begin
        cmd.op = rqms_pkg::OP_MOD;
        if (cnt_r == rqms_pkg::CNT_W'(rqms_pkg::MOD_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = rqms_pkg::S_FOLD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      rqms_pkg::S_FOLD: begin cmd.op = rqms_pkg::OP_FOLD; state_nxt = rqms_pkg::S_CORD; end
      rqms_pkg::S_CORD: begin
        cmd.op = rqms_pkg::OP_CORD;
        if (cnt_r == rqms_pkg::CNT_W'(rqms_pkg::CORDIC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = rqms_pkg::S_SC;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      rqms_pkg::S_SC:  begin cmd.op = rqms_pkg::OP_SC;  state_nxt = rqms_pkg::S_REL; end
      rqms_pkg::S_REL: begin cmd.op = rqms_pkg::OP_REL; state_nxt = rqms_pkg::S_P0;  end
      rqms_pkg::S_P0:  begin cmd.op = rqms_pkg::OP_P0;  state_nxt = rqms_pkg::S_P1;  end
      rqms_pkg::S_P1:  begin cmd.op = rqms_pkg::OP_P1;  state_nxt = rqms_pkg::S_P2;  end
      rqms_pkg::S_P2:  begin cmd.op = rqms_pkg::OP_P2;  state_nxt = rqms_pkg::S_P3;  end
      rqms_pkg::S_P3:  begin cmd.op = rqms_pkg::OP_P3;  state_nxt = rqms_pkg::S_P4;  end
      rqms_pkg::S_P4:  begin cmd.op = rqms_pkg::OP_P4;  state_nxt = rqms_pkg::S_EMIT; end
      rqms_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.op = rqms_pkg::OP_EMIT;
          if (cnt_r == rqms_pkg::CNT_W'(rqms_pkg::CORNERS - 1)) begin
            cnt_nxt   = '0;
            state_nxt = rqms_pkg::S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = rqms_pkg::S_REL;
          end
        end
      end
      default: state_nxt = rqms_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### sv/rqms_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module rqms_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  rqms_in_if.sink            in_ch,
  rqms_out_if.source         out_ch,
  input  rqms_pkg::dp_cmd_t  cmd,
  output rqms_pkg::dp_stat_t stat
);

  logic signed [31:0] left_r, right_r, down_r, up_r, rate_r;
  logic [16:0] gain_r;
  logic signed [31:0] cx_r [rqms_pkg::CORNERS];
  logic signed [31:0] cy_r [rqms_pkg::CORNERS];
  logic signed [31:0] spx_r, spy_r;

  logic [15:0] dt_r;
  logic signed [67:0] prod_r;
  logic signed [31:0] dispx_r, dispy_r, angle_r, cenx_r, ceny_r;
  logic signed [33:0] sumx_r, sumy_r;
  logic hitx_r, hity_r, neg_r;
  logic [32:0] u_r;
  logic [rqms_pkg::QUOT_W-1:0] q_r;
  logic [18:0] rem_r;
  logic signed [33:0] x_r, y_r, z_r, c_r, s_r;
  logic signed [32:0] rx_r, ry_r;
  logic signed [35:0] accx_r, accy_r;
  logic out_valid_r, out_last_r;
  logic [1:0] out_idx_r;
  logic [31:0] out_x_r, out_y_r;

  logic signed [33:0] mul_a, mul_b;
  logic signed [17:0] gain_eff;
  logic [rqms_pkg::IDX_W-1:0] k;
  logic signed [33:0] px, py;
  logic [32:0] mod_diff;
  logic signed [20:0] r0, r1;
  logic signed [33:0] cdx, cdy;
  logic [31:0] at;
  logic signed [35:0] p30;

  assign k = cmd.idx;
  assign gain_eff = (gain_r > rqms_pkg::GAIN_ONE) ? 18'sd65536 : $signed({1'b0, gain_r});
  assign px = 34'(cx_r[k]) + 34'(dispx_r);
  assign py = 34'(cy_r[k]) + 34'(dispy_r);
  // biased angle minus quotient estimate times 2pi, lands in [0, 4pi)
  assign mod_diff = u_r - prod_r[32:0];
  assign cdx = y_r >>> cmd.step;
  assign cdy = x_r >>> cmd.step;
  assign at = rqms_pkg::atan_q30(cmd.step);
  assign p30 = 36'(prod_r >>> 30);

  always_comb begin
    r0 = $signed({2'b00, rem_r});
    if (r0 > rqms_pkg::PI_Q16) r0 = r0 - rqms_pkg::TWO_PI_Q16;
    r1 = r0;
    if (r0 > rqms_pkg::HALF_PI_Q16) r1 = r0 - rqms_pkg::PI_Q16;
    else if (r0 < -rqms_pkg::HALF_PI_Q16) r1 = r0 + rqms_pkg::PI_Q16;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      rqms_pkg::OP_DX, rqms_pkg::OP_RX: begin
        mul_a = 34'(spx_r); mul_b = $signed({18'd0, dt_r});
      end
      rqms_pkg::OP_DY, rqms_pkg::OP_RY: begin
        mul_a = 34'(spy_r); mul_b = $signed({18'd0, dt_r});
      end
      rqms_pkg::OP_ANG: begin
        mul_a = 34'(rate_r); mul_b = $signed({18'd0, dt_r});
      end
      rqms_pkg::OP_BX: begin mul_a = -34'(spx_r); mul_b = 34'(gain_eff); end
      rqms_pkg::OP_BY: begin mul_a = -34'(spy_r); mul_b = 34'(gain_eff); end
      rqms_pkg::OP_MOD: begin
        if (cmd.step == rqms_pkg::MOD_QUOT) begin
          mul_a = $signed(34'(u_r)); mul_b = rqms_pkg::MOD_RECIP;
        end else if (cmd.step == rqms_pkg::MOD_BACK) begin
          mul_a = $signed(34'(q_r)); mul_b = 34'(rqms_pkg::TWO_PI_Q16);
        end
      end
      rqms_pkg::OP_P0: begin mul_a = 34'(rx_r); mul_b = c_r; end
      rqms_pkg::OP_P1: begin mul_a = 34'(ry_r); mul_b = s_r; end
      rqms_pkg::OP_P2: begin mul_a = 34'(rx_r); mul_b = s_r; end
      rqms_pkg::OP_P3: begin mul_a = 34'(ry_r); mul_b = c_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= -32'sd65536;
      right_r <= 32'sd65536;
      down_r  <= -32'sd65536;
      up_r    <= 32'sd65536;
      gain_r  <= rqms_pkg::GAIN_ONE;
      rate_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rqms_pkg::REG_LEFT:  left_r  <= cfg_data;
        rqms_pkg::REG_RIGHT: right_r <= cfg_data;
        rqms_pkg::REG_DOWN:  down_r  <= cfg_data;
        rqms_pkg::REG_UP:    up_r    <= cfg_data;
        rqms_pkg::REG_GAIN:  gain_r  <= cfg_data[16:0];
        rqms_pkg::REG_RATE:  rate_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rqms_pkg::CORNERS; i++) begin
        cx_r[i] <= '0;
        cy_r[i] <= '0;
      end
      spx_r <= '0;
      spy_r <= '0;
    end else begin
      case (cmd.op)
        rqms_pkg::OP_LOAD: begin
          if (in_ch.cmd == rqms_pkg::CMD_CORNER) begin
            cx_r[in_ch.vertex_index] <= in_ch.x_value;
            cy_r[in_ch.vertex_index] <= in_ch.y_value;
          end else if (in_ch.cmd == rqms_pkg::CMD_SPEED) begin
            spx_r <= in_ch.x_value;
            spy_r <= in_ch.y_value;
          end
        end
        rqms_pkg::OP_BY: if (hitx_r) spx_r <= rqms_pkg::sat40(40'(prod_r >>> 16));
        rqms_pkg::OP_RX: if (hity_r) spy_r <= rqms_pkg::sat40(40'(prod_r >>> 16));
        rqms_pkg::OP_EMIT: begin
          cx_r[k] <= rqms_pkg::sat40(40'(cenx_r) + 40'(accx_r));
          cy_r[k] <= rqms_pkg::sat40(40'(ceny_r) + 40'(accy_r));
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      rqms_pkg::OP_LOAD: dt_r <= in_ch.time_step;
      rqms_pkg::OP_DY, rqms_pkg::OP_RY: dispx_r <= prod_r[47:16];
      rqms_pkg::OP_ANG, rqms_pkg::OP_MODI: begin
        dispy_r <= prod_r[47:16];
        sumx_r  <= '0;
        sumy_r  <= '0;
        hitx_r  <= 1'b0;
        hity_r  <= 1'b0;
        u_r     <= 33'($signed(33'(angle_r)) + $signed(rqms_pkg::MOD_BIAS));
        rem_r   <= '0;
      end
      rqms_pkg::OP_HIT: begin
        if (k == '0) angle_r <= prod_r[47:16];
        sumx_r <= sumx_r + 34'(cx_r[k]);
        sumy_r <= sumy_r + 34'(cy_r[k]);
        if (px <= 34'(left_r) || px >= 34'(right_r)) hitx_r <= 1'b1;
        if (py <= 34'(down_r) || py >= 34'(up_r)) hity_r <= 1'b1;
      end
      rqms_pkg::OP_BX: begin
        cenx_r <= 32'(sumx_r >>> 2);
        ceny_r <= 32'(sumy_r >>> 2);
      end
      rqms_pkg::OP_MOD: begin
        if (cmd.step == rqms_pkg::MOD_TAKE) begin
          q_r <= prod_r[rqms_pkg::RECIP_SHIFT +: rqms_pkg::QUOT_W];
        end else if (cmd.step == rqms_pkg::MOD_REM) begin
          if (mod_diff >= 33'(rqms_pkg::TWO_PI_Q16))
            rem_r <= 19'(mod_diff - 33'(rqms_pkg::TWO_PI_Q16));
          else rem_r <= mod_diff[18:0];
        end
      end
      rqms_pkg::OP_FOLD: begin
        neg_r <= (r0 > rqms_pkg::HALF_PI_Q16) || (r0 < -rqms_pkg::HALF_PI_Q16);
        z_r   <= 34'(r1) <<< 14;
        x_r   <= rqms_pkg::CORDIC_K_Q30;
        y_r   <= '0;
      end
      rqms_pkg::OP_CORD: begin
        if (!z_r[33]) begin
          x_r <= x_r - cdx; y_r <= y_r + cdy; z_r <= z_r - $signed({2'b00, at});
        end else begin
          x_r <= x_r + cdx; y_r <= y_r - cdy; z_r <= z_r + $signed({2'b00, at});
        end
      end
      rqms_pkg::OP_SC: begin
        c_r <= neg_r ? -x_r : x_r;
        s_r <= neg_r ? -y_r : y_r;
      end
      rqms_pkg::OP_REL: begin
        rx_r <= 33'($signed(rqms_pkg::sat40(40'(cx_r[k]) + 40'(dispx_r)))) - 33'(cenx_r);
        ry_r <= 33'($signed(rqms_pkg::sat40(40'(cy_r[k]) + 40'(dispy_r)))) - 33'(ceny_r);
      end
      rqms_pkg::OP_P1: accx_r <= p30;
      rqms_pkg::OP_P2: accx_r <= accx_r - p30;
      rqms_pkg::OP_P3: accy_r <= p30;
      rqms_pkg::OP_P4: accy_r <= accy_r + p30;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == rqms_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == rqms_pkg::OP_EMIT) begin
      out_idx_r  <= 2'(k);
      out_x_r    <= rqms_pkg::sat40(40'(cenx_r) + 40'(accx_r));
      out_y_r    <= rqms_pkg::sat40(40'(ceny_r) + 40'(accy_r));
      out_last_r <= (k == rqms_pkg::IDX_W'(rqms_pkg::CORNERS - 1));
    end
  end

  assign stat.out_free       = !out_valid_r || out_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.corner_index = out_idx_r;
  assign out_ch.x_pos        = out_x_r;
  assign out_ch.y_pos        = out_y_r;
  assign out_ch.last         = out_last_r;

endmodule
`default_nettype wire

### bench/rigid_quad_motion_step_unit_tb.sv
`timescale 1ns / 1ps
module rigid_quad_motion_step_unit_tb;
  import rqms_pkg::*;

  typedef struct {
    logic [1:0]  idx;
    logic [31:0] xp;
    logic [31:0] yp;
    logic        lst;
  } corner_rpt_t;

  int fail_count = 0;

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= 40) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Behavioral copy of the quad: state, walls and the tick arithmetic.
  class quad_scoreboard;
    logic signed [31:0] wall_l, wall_r, wall_d, wall_u, spin;
    logic [16:0]        elastic;
    logic signed [31:0] px[4], py[4];
    logic signed [31:0] vx, vy;
    corner_rpt_t        pending[$];
    int                 seen;

    function new();
      wall_l = -32'sd65536; wall_r = 32'sd65536;
      wall_d = -32'sd65536; wall_u = 32'sd65536;
      elastic = GAIN_ONE; spin = 0; vx = 0; vy = 0; seen = 0;
      for (int k = 0; k < 4; k++) begin
        px[k] = 0; py[k] = 0;
      end
    endfunction

    function void write_reg(reg_idx_t r, logic [31:0] d);
      case (r)
        REG_LEFT:  wall_l = d;
        REG_RIGHT: wall_r = d;
        REG_DOWN:  wall_d = d;
        REG_UP:    wall_u = d;
        REG_GAIN:  elastic = d[16:0];
        REG_RATE:  spin = d;
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clamp(longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function bit wall_hit(logic signed [31:0] p[4], longint d,
                          logic signed [31:0] lo, logic signed [31:0] hi);
      longint q;
      for (int k = 0; k < 4; k++) begin
        q = longint'(p[k]) + d;
        if (q <= longint'(lo) || q >= longint'(hi)) return 1;
      end
      return 0;
    endfunction

    function void sincos(longint ang, output longint s, output longint c);
      longint r, x, y, z, dx, dy, at;
      bit flip;
      r = ang % 411775;
      flip = 0;
      if (r < 0) r += 411775;
      if (r > 205887) r -= 411775;
      if (r > 102944) begin
        r -= 205887; flip = 1;
      end else if (r < -102944) begin
        r += 205887; flip = 1;
      end
      x = 652032874; y = 0; z = r * 16384;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i; dy = x >>> i;
        at = (i < 11) ? longint'(atan_q30(i)) : (longint'(1) << (30 - i));
        if (z >= 0) begin
          x -= dx; y += dy; z -= at;
        end else begin
          x += dx; y -= dy; z += at;
        end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function void note_input(cmd_t op, logic [1:0] vi, logic [31:0] xv,
                             logic [31:0] yv, logic [15:0] dt);
      longint g, dxs, dys, cx, cy, s, c, rx, ry, nx, ny, t;
      corner_rpt_t e;
      if (op == CMD_CORNER) begin
        px[vi] = xv; py[vi] = yv; return;
      end
      if (op == CMD_SPEED) begin
        vx = xv; vy = yv; return;
      end
      if (op != CMD_TICK) return;
      t = dt;
      g = (elastic > GAIN_ONE) ? 65536 : elastic;
      dxs = (longint'(vx) * t) >>> 16;
      dys = (longint'(vy) * t) >>> 16;
      if (wall_hit(px, dxs, wall_l, wall_r)) vx = clamp((-longint'(vx) * g) >>> 16);
      if (wall_hit(py, dys, wall_d, wall_u)) vy = clamp((-longint'(vy) * g) >>> 16);
      dxs = (longint'(vx) * t) >>> 16;
      dys = (longint'(vy) * t) >>> 16;
      cx = 0; cy = 0;
      for (int k = 0; k < 4; k++) begin
        cx += px[k]; cy += py[k];
      end
      cx = cx >>> 2; cy = cy >>> 2;
      sincos((longint'(spin) * t) >>> 16, s, c);
      for (int k = 0; k < 4; k++) begin
        rx = longint'(clamp(longint'(px[k]) + dxs)) - cx;
        ry = longint'(clamp(longint'(py[k]) + dys)) - cy;
        nx = ((rx * c) >>> 30) - ((ry * s) >>> 30);
        ny = ((rx * s) >>> 30) + ((ry * c) >>> 30);
        px[k] = clamp(cx + nx);
        py[k] = clamp(cy + ny);
        e.idx = k; e.xp = px[k]; e.yp = py[k]; e.lst = (k == 3);
        pending.push_back(e);
      end
    endfunction

    task check_result(logic [1:0] ci, logic [31:0] xp, logic [31:0] yp,
                      logic lst);
      corner_rpt_t e;
      seen++;
      if (pending.size() == 0) begin
        report_mismatch("corner transfer with nothing pending"); return;
      end
      e = pending.pop_front();
      if (ci !== e.idx)
        report_mismatch($sformatf("corner_index %0d want %0d", ci, e.idx));
      if (xp !== e.xp)
        report_mismatch($sformatf("corner %0d x_pos %h want %h", e.idx, xp, e.xp));
      if (yp !== e.yp)
        report_mismatch($sformatf("corner %0d y_pos %h want %h", e.idx, yp, e.yp));
      if (lst !== e.lst)
        report_mismatch($sformatf("corner %0d last %b want %b", e.idx, lst, e.lst));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  int tick_count = 0;
  int moved = 0;       // transfers since the watchdog last cleared
  bit stall_rx = 0;    // receiver hold-off request
  bit no_idle = 0;     // stretch with no random gaps on either side
  bit done = 0;

  rqms_in_if  in_ch ();
  rqms_out_if out_ch ();
  quad_scoreboard sb = new();

  rigid_quad_motion_step_unit DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    in_ch.valid = 0; in_ch.cmd = CMD_TICK; in_ch.vertex_index = 0;
    in_ch.x_value = 0; in_ch.y_value = 0; in_ch.time_step = 0;
    out_ch.ready = 0;
  end

  // Monitor: input transfers feed the prediction, output transfers are checked.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      moved++;
      if (in_ch.cmd == CMD_TICK) tick_count++;
      sb.note_input(cmd_t'(in_ch.cmd), in_ch.vertex_index, in_ch.x_value,
                    in_ch.y_value, in_ch.time_step);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      moved++;
      sb.check_result(out_ch.corner_index, out_ch.x_pos, out_ch.y_pos,
                      out_ch.last);
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 0;
    else if (stall_rx) out_ch.ready <= 0;
    else out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 7);
  end

  // Watchdog: cycles without any transfer.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (moved != 0 || stall_rx || !rst_n) quiet = 0;
      else quiet++;
      moved = 0;
      if (quiet >= 4000) begin
        $display("Watchdog expired with %0d corners pending", sb.pending.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // One item: hold valid until the transfer, with random gaps before.
  task automatic send_item(cmd_t op, logic [1:0] vi, logic [31:0] xv,
                           logic [31:0] yv, logic [15:0] dt);
    while (!no_idle && $urandom_range(99) < 7) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1; in_ch.cmd <= op; in_ch.vertex_index <= vi;
    in_ch.x_value <= xv; in_ch.y_value <= yv; in_ch.time_step <= dt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_raw(logic [1:0] op, logic [1:0] vi, logic [31:0] xv,
                          logic [31:0] yv, logic [15:0] dt);
    in_ch.valid <= 1; in_ch.cmd <= op; in_ch.vertex_index <= vi;
    in_ch.x_value <= xv; in_ch.y_value <= yv; in_ch.time_step <= dt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Idle the input and wait until every predicted corner has arrived.
  task automatic drain();
    stop_sending();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_cfg(reg_idx_t r, logic [31:0] d);
    cfg_we <= 1; cfg_index <= r; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(r, d);
  endtask

  function automatic logic [31:0] rnd_pos(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  // Well-formed frame: load some of the corners, maybe a velocity, then one to three ticks.
  task automatic random_frame(int span, int vspan);
    logic [31:0] bx, by;
    bx = rnd_pos(span); by = rnd_pos(span);
    for (int k = 0; k < 4; k++)
      if ($urandom_range(3) != 0)
        send_item(CMD_CORNER, k, bx + rnd_pos(span / 4), by + rnd_pos(span / 4), $urandom);
    if ($urandom_range(1)) send_item(CMD_SPEED, $urandom, rnd_pos(vspan), rnd_pos(vspan),
                                     $urandom);
    repeat ($urandom_range(3, 1)) send_item(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int sent;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, all commands, bounce, zero step, saturation.
    send_item(CMD_TICK, 0, 0, 0, 16'hFFFF);
    send_item(CMD_CORNER, 0, 32'h0000_8000, 32'h0000_8000, 0);
    send_item(CMD_CORNER, 1, 32'hFFFF_8000, 32'h0000_8000, 0);
    send_item(CMD_CORNER, 2, 32'hFFFF_8000, 32'hFFFF_8000, 0);
    send_item(CMD_CORNER, 3, 32'h0000_8000, 32'hFFFF_8000, 0);
    send_item(CMD_SPEED, 0, 32'h0002_0000, 32'hFFFE_0000, 0);
    send_item(CMD_TICK, 0, 0, 0, 16'h8000);
    send_item(CMD_TICK, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
    send_raw(2'd3, 2'd3, 32'hFFFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_item(CMD_SPEED, 3, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_item(CMD_CORNER, 2, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_item(CMD_TICK, 0, 0, 0, 16'hFFFF);
    drain();

    // Wide-open walls, half gain, fast spin.
    write_cfg(REG_LEFT, 32'h8000_0000); write_cfg(REG_RIGHT, 32'h7FFF_FFFF);
    write_cfg(REG_DOWN, 32'h8000_0000); write_cfg(REG_UP, 32'h7FFF_FFFF);
    write_cfg(REG_GAIN, 32'h0000_8000); write_cfg(REG_RATE, 32'h0006_4000);
    send_item(CMD_SPEED, 1, 32'h0001_0000, 32'h0000_4000, 0);
    send_item(CMD_CORNER, 1, 32'h0001_0000, 32'h0002_0000, 0);
    send_item(CMD_TICK, 1, 0, 0, 16'hFFFF);
    send_item(CMD_TICK, 2, 0, 0, 16'h0001);
    drain();

    // Inverted walls, gain above one, extreme negative spin.
    write_cfg(REG_LEFT, 32'h7FFF_FFFF); write_cfg(REG_RIGHT, 32'h8000_0000);
    write_cfg(REG_DOWN, 32'h0000_0000); write_cfg(REG_UP, 32'h0000_0000);
    write_cfg(REG_GAIN, 32'h0001_FFFF); write_cfg(REG_RATE, 32'h8000_0000);
    send_item(CMD_TICK, 0, 0, 0, 16'h1234);
    send_item(CMD_TICK, 0, 0, 0, 16'hFFFF);
    drain();
    write_cfg(REG_GAIN, 32'h0000_0000); write_cfg(REG_RATE, 32'h7FFF_FFFF);
    send_item(CMD_TICK, 0, 0, 0, 16'hFFFF);
    drain();

    // Back pressure: receiver holds off while ticks keep coming.
    fork
      begin
        stall_rx = 1;
        repeat (600) @(posedge clk);
        stall_rx = 0;
      end
      repeat (6) send_item(CMD_TICK, 0, $urandom, $urandom, $urandom);
    join
    drain();

    // Random phases with different wall/gain/spin settings.
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(REG_LEFT, rnd_pos(32'h0004_0000) - 32'h0001_0000);
      write_cfg(REG_RIGHT, rnd_pos(32'h0004_0000) + 32'h0001_0000);
      write_cfg(REG_DOWN, (ph == 5) ? 32'h8000_0000 : rnd_pos(32'h0004_0000));
      write_cfg(REG_UP, (ph == 5) ? 32'h7FFF_FFFF : rnd_pos(32'h0004_0000));
      write_cfg(REG_GAIN, $urandom_range(32'h1_FFFF));
      write_cfg(REG_RATE, (ph == 0) ? 32'h0 : ((ph == 4) ? $urandom : rnd_pos(32'h0010_0000)));
      no_idle = (ph == 2);
      while (sent < 58) begin
        if ($urandom_range(9) == 0) begin
          if ($urandom_range(1))
            send_raw(2'd3, $urandom, $urandom, $urandom, $urandom);
          else
            send_item(cmd_t'($urandom_range(2)), $urandom, $urandom, $urandom, $urandom);
          sent++;
        end else begin
          random_frame((ph == 3) ? 32'h4000_0000 : 32'h0003_0000,
                       (ph == 3) ? 32'h7FFF_FFFF : 32'h0008_0000);
          sent += 5;
        end
      end
      sent = 0;
      no_idle = 0;
      drain();
    end

    done = 1;
    $display("Covered %0d ticks, %0d corners checked, across six wall/gain/spin settings,",
             tick_count, sb.seen);
    $display("including inverted walls, saturation, unknown commands and output back pressure.");
    if (fail_count == 0 && sb.pending.size() == 0)
      $display("No mismatches found");
    else begin
      if (sb.pending.size() != 0)
        $display("%0d expected corners never arrived", sb.pending.size());
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
